// ----- rtl/core/psnc_pkg.sv -----
// shared types and constants of the palette store with nearest-colour search
`default_nettype none

package psnc_pkg;

  // field widths of the transactions
  localparam int ACTION_W   = 3;
  localparam int COLOR_W    = 24;
  localparam int WIDX_W     = 9;
  localparam int RES_IDX_W  = 5;
  localparam int COUNT_W    = 6;
  localparam int CH_W       = 8;
  localparam int SQ_W       = 2 * CH_W;
  localparam int DIST_W     = SQ_W + 2;

  // packed payload widths, padded to whole bytes
  localparam int IN_BITS      = ACTION_W + COLOR_W + WIDX_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS     = 1 + RES_IDX_W + COLOR_W + COUNT_W + RES_IDX_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR       = 3'd0,
    ACT_ADD         = 3'd1,
    ACT_SEL_INDEX   = 3'd2,
    ACT_SEL_NEAREST = 3'd3,
    ACT_READ        = 3'd4
  } action_t;

endpackage

`default_nettype wire

// ----- rtl/core/psnc_dist.sv -----
// squared rgb distance unit shared by every step of the nearest search
`default_nettype none

module psnc_dist
  import psnc_pkg::*;
(
  input  wire logic [COLOR_W-1:0] a_color,
  input  wire logic [COLOR_W-1:0] b_color,
  output logic      [DIST_W-1:0]  dist_sum
);

  logic [CH_W-1:0] diff [3];
  logic [SQ_W-1:0] sq   [3];

  // absolute channel differences and their squares
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (a_color[c*CH_W +: CH_W] > b_color[c*CH_W +: CH_W]) begin
        diff[c] = a_color[c*CH_W +: CH_W] - b_color[c*CH_W +: CH_W];
      end else begin
        diff[c] = b_color[c*CH_W +: CH_W] - a_color[c*CH_W +: CH_W];
      end
      sq[c] = SQ_W'(diff[c]) * SQ_W'(diff[c]);
    end
  end

  // sum of the three squares
  assign dist_sum = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);

endmodule

`default_nettype wire

// ----- rtl/core/palette_store_nearest_color_top.sv -----
// palette store: clear, add, select by index, select nearest colour, read
// clear, add and read answer from a registered result; select index reads the swatch memory
//   through pick and load states; select nearest scans one swatch per cycle through the shared unit
// one transaction at a time: the next is taken the cycle after the result is taken
// synchronous active-low reset empties the palette and drops the selection
`default_nettype none

module palette_store_nearest_color_top
  import psnc_pkg::*;
#(
  parameter int PALETTE_DEPTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // action [2:0], color_in [26:3], wanted_index [35:27]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // failed [0], result_index [5:1], current_color [29:6], entry_count [35:30],
  // selected_index [40:36], selection_valid [41]
  output logic      [OUT_TDATA_W-1:0] out_tdata
);

  localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(PALETTE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_LOAD,
    ST_OUT
  } state_t;

  state_t                   state_r;
  logic [CNT_W-1:0]         count_r;
  logic [IDX_W-1:0]         sel_r;
  logic                     has_sel_r;
  logic [COLOR_W-1:0]       cur_color_r;
  logic                     failed_r;
  logic [IDX_W-1:0]         res_idx_r;
  logic [COLOR_W-1:0]       color_r;
  logic [CNT_W-1:0]         addr_r;
  logic                     dat_vld_r;
  logic [IDX_W-1:0]         dat_idx_r;
  logic [COLOR_W-1:0]       rd_data_r;
  logic [DIST_W-1:0]        best_r;
  logic [IDX_W-1:0]         best_idx_r;
  logic [COLOR_W-1:0]       best_col_r;
  logic [COLOR_W-1:0]       swatches_r [PALETTE_DEPTH];

  action_t                  in_action;
  logic [COLOR_W-1:0]       in_color;
  logic [WIDX_W-1:0]        in_widx;
  logic                     in_fire;
  logic                     full;
  logic                     wr_en;
  logic                     rd_en;
  logic                     issue;
  logic [WIDX_W-1:0]        cnt9;
  logic [WIDX_W-1:0]        pick9;
  logic [IDX_W-1:0]         pick;
  logic [DIST_W-1:0]        cand_dist;
  logic                     take;
  logic                     scan_last;
  logic [IDX_W+RES_IDX_W-1:0] sel_ext;
  logic [IDX_W+RES_IDX_W-1:0] res_ext;
  logic [CNT_W+COUNT_W-1:0]   cnt_ext;

  // input unpacking
  assign in_action = action_t'(in_tdata[ACTION_W-1:0]);
  assign in_color  = in_tdata[ACTION_W +: COLOR_W];
  assign in_widx   = in_tdata[ACTION_W+COLOR_W +: WIDX_W];

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign in_fire    = in_tvalid && in_tready;
  assign full       = (count_r == DEPTH_C);

  // clamp the requested slot into 0 .. count-1
  assign cnt9 = WIDX_W'(count_r);
  always_comb begin
    priority if (in_widx[WIDX_W-1]) begin
      pick9 = '0;
    end else if ({1'b0, in_widx[WIDX_W-2:0]} >= cnt9) begin
      pick9 = cnt9 - WIDX_W'(1);
    end else begin
      pick9 = in_widx;
    end
  end
  assign pick = IDX_W'(pick9);

  // swatch memory, one write and one registered read port
  assign wr_en = in_fire && (in_action == ACT_ADD) && !full;
  assign issue = (addr_r < count_r);
  assign rd_en = ((state_r == ST_SCAN) && issue) || (state_r == ST_PICK);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      swatches_r[count_r[IDX_W-1:0]] <= in_color;
    end
    if (rd_en) begin
      rd_data_r <= swatches_r[addr_r[IDX_W-1:0]];
    end
  end

  // shared distance unit
  psnc_dist u_dist (
    .a_color  (rd_data_r),
    .b_color  (color_r),
    .dist_sum (cand_dist)
  );

  // earliest entry wins ties, so only a strictly smaller distance replaces
  assign take      = (dat_idx_r == '0) || (cand_dist < best_r);
  assign scan_last = (CNT_W'(dat_idx_r) == (count_r - CNT_W'(1)));

  // sequencer and palette state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      sel_r       <= '0;
      has_sel_r   <= 1'b0;
      cur_color_r <= '0;
      dat_vld_r   <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            failed_r  <= 1'b0;
            res_idx_r <= '0;
            color_r   <= in_color;
            dat_vld_r <= 1'b0;
            state_r   <= ST_OUT;
            unique case (in_action)
              ACT_CLEAR: begin
                count_r     <= '0;
                sel_r       <= '0;
                has_sel_r   <= 1'b0;
                cur_color_r <= '0;
              end
              ACT_ADD: begin
                if (full) begin
                  failed_r <= 1'b1;
                end else begin
                  res_idx_r <= count_r[IDX_W-1:0];
                  count_r   <= count_r + CNT_W'(1);
                  if (!has_sel_r) begin
                    sel_r       <= '0;
                    has_sel_r   <= 1'b1;
                    cur_color_r <= in_color;
                  end
                end
              end
              ACT_SEL_INDEX: begin
                if (count_r == '0) begin
                  failed_r <= 1'b1;
                end else begin
                  addr_r  <= CNT_W'(pick);
                  state_r <= ST_PICK;
                end
              end
              ACT_SEL_NEAREST: begin
                if (count_r == '0) begin
                  failed_r <= 1'b1;
                end else begin
                  addr_r  <= '0;
                  state_r <= ST_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_PICK: begin
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          sel_r       <= addr_r[IDX_W-1:0];
          res_idx_r   <= addr_r[IDX_W-1:0];
          has_sel_r   <= 1'b1;
          cur_color_r <= rd_data_r;
          state_r     <= ST_OUT;
        end
        ST_SCAN: begin
          // the read address has passed the count by the last entry, so valid drops
          dat_vld_r <= issue;
          dat_idx_r <= addr_r[IDX_W-1:0];
          if (issue) begin
            addr_r <= addr_r + CNT_W'(1);
          end
          if (dat_vld_r) begin
            if (take) begin
              best_r     <= cand_dist;
              best_idx_r <= dat_idx_r;
              best_col_r <= rd_data_r;
            end
            if (scan_last) begin
              sel_r       <= take ? dat_idx_r : best_idx_r;
              res_idx_r   <= take ? dat_idx_r : best_idx_r;
              cur_color_r <= take ? rd_data_r : best_col_r;
              has_sel_r   <= 1'b1;
              state_r     <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (out_tready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // result packing, indexes and count fitted to the field widths
  assign sel_ext = (IDX_W+RES_IDX_W)'(sel_r);
  assign res_ext = (IDX_W+RES_IDX_W)'(res_idx_r);
  assign cnt_ext = (CNT_W+COUNT_W)'(count_r);

  assign out_tdata = OUT_TDATA_W'({has_sel_r,
                                   sel_ext[RES_IDX_W-1:0],
                                   cnt_ext[COUNT_W-1:0],
                                   cur_color_r,
                                   res_ext[RES_IDX_W-1:0],
                                   failed_r});

endmodule

`default_nettype wire

// ----- rtl/core/psnc_checker.sv -----
// port-level checks on the palette store, bound to its top level
`default_nettype none

module psnc_checker
  import psnc_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [IN_TDATA_W-1:0]  in_tdata,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  // a waiting input transaction holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input changed while waiting");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no new transaction is taken while a result waits
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while result pending");

  // a failed action reports slot zero
  a_failed_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[5:1] == 5'd0)
    else $error("failed result carries a slot");

  // without a selection the colour is black and the selection reads zero
  a_no_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[41] |-> out_tdata[29:6] == 24'd0 && out_tdata[40:36] == 5'd0)
    else $error("colour or index shown without a selection");

endmodule

bind palette_store_nearest_color_top psnc_checker u_psnc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// testbench of the palette store: directed and random transactions checked against a predictor

module tb;
  import psnc_pkg::*;

  localparam int DEPTH        = 32;
  localparam int DRAIN_CYCLES = DEPTH + 8;
  localparam int RUN_LIMIT_NS = 5_000_000;

  // result field positions in out_tdata
  localparam int OUT_IDX_LSB    = 1;
  localparam int OUT_COLOUR_LSB = OUT_IDX_LSB + RES_IDX_W;
  localparam int OUT_COUNT_LSB  = OUT_COLOUR_LSB + COLOR_W;
  localparam int OUT_SEL_LSB    = OUT_COUNT_LSB + COUNT_W;
  localparam int OUT_VALID_BIT  = OUT_SEL_LSB + RES_IDX_W;

  typedef struct packed {
    logic                 failed;
    logic [RES_IDX_W-1:0] res_index;
    logic [COLOR_W-1:0]   colour;
    logic [COUNT_W-1:0]   count;
    logic [RES_IDX_W-1:0] sel_index;
    logic                 sel_valid;
  } palette_result_t;

  typedef logic [COLOR_W-1:0] colour_q_t[$];

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // action [2:0], color_in [26:3], wanted_index [35:27]
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // failed [0], result_index [5:1], current_color [29:6], entry_count [35:30],
  // selected_index [40:36], selection_valid [41]
  logic [OUT_TDATA_W-1:0] out_tdata;

  // predictor copy of the palette
  logic [COLOR_W-1:0] pal_swatch [DEPTH];
  int unsigned        pal_count = 0;
  int unsigned        pal_sel = 0;
  bit                 pal_has_sel = 1'b0;

  palette_result_t palette_results_due[$];
  int              err_count = 0;
  int              send_idle_pct = 0;
  int              stall_pct = 0;

  palette_store_nearest_color_top #(
    .PALETTE_DEPTH(DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("[palette_store_nearest_color_top] ERROR");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [COLOR_W-1:0] got, logic [COLOR_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  function automatic int unsigned colour_distance(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
    int unsigned sum;
    int          diff;
    sum = 0;
    for (int ch = 0; ch < 3; ch++) begin
      diff = int'(a[ch*CH_W +: CH_W]) - int'(b[ch*CH_W +: CH_W]);
      sum += diff * diff;
    end
    return sum;
  endfunction

  // apply one action to the predictor state and return the result it reports
  function automatic palette_result_t predict_palette_action(logic [ACTION_W-1:0] act,
                                                             logic [COLOR_W-1:0] colour,
                                                             logic [WIDX_W-1:0] widx);
    palette_result_t r;
    int unsigned     best_dist;
    int unsigned     cand_dist;
    int unsigned     best_at;
    r = '0;
    case (act)
      ACT_CLEAR: begin
        pal_count   = 0;
        pal_sel     = 0;
        pal_has_sel = 1'b0;
      end
      ACT_ADD: begin
        if (pal_count >= DEPTH) begin
          r.failed = 1'b1;
        end else begin
          pal_swatch[pal_count] = colour;
          r.res_index = RES_IDX_W'(pal_count);
          pal_count++;
          if (!pal_has_sel) begin
            pal_sel     = 0;
            pal_has_sel = 1'b1;
          end
        end
      end
      ACT_SEL_INDEX: begin
        if (pal_count == 0) begin
          r.failed = 1'b1;
        end else begin
          // negative picks slot 0, too large picks the last slot
          if (widx[WIDX_W-1])
            pal_sel = 0;
          else if (widx >= pal_count)
            pal_sel = pal_count - 1;
          else
            pal_sel = 32'(widx);
          pal_has_sel = 1'b1;
          r.res_index = RES_IDX_W'(pal_sel);
        end
      end
      ACT_SEL_NEAREST: begin
        if (pal_count == 0) begin
          r.failed = 1'b1;
        end else begin
          // strict less-than so the earliest slot wins a tie
          best_at   = 0;
          best_dist = colour_distance(pal_swatch[0], colour);
          for (int i = 1; i < pal_count; i++) begin
            cand_dist = colour_distance(pal_swatch[i], colour);
            if (cand_dist < best_dist) begin
              best_dist = cand_dist;
              best_at   = i;
            end
          end
          pal_sel     = best_at;
          pal_has_sel = 1'b1;
          r.res_index = RES_IDX_W'(best_at);
        end
      end
      default: ;
    endcase
    r.colour    = (pal_has_sel && pal_sel < pal_count) ? pal_swatch[pal_sel] : '0;
    r.count     = COUNT_W'(pal_count);
    r.sel_index = pal_has_sel ? RES_IDX_W'(pal_sel) : '0;
    r.sel_valid = pal_has_sel;
    return r;
  endfunction

  // receiver side stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // predict on each accepted input, compare each accepted result
  always @(posedge clk) begin : result_check
    palette_result_t want;
    palette_result_t seen;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen.failed    = out_tdata[0];
        seen.res_index = out_tdata[OUT_IDX_LSB +: RES_IDX_W];
        seen.colour    = out_tdata[OUT_COLOUR_LSB +: COLOR_W];
        seen.count     = out_tdata[OUT_COUNT_LSB +: COUNT_W];
        seen.sel_index = out_tdata[OUT_SEL_LSB +: RES_IDX_W];
        seen.sel_valid = out_tdata[OUT_VALID_BIT];
        if (palette_results_due.size() == 0) begin
          report_mismatch($sformatf("result %h with none expected", out_tdata));
        end else begin
          want = palette_results_due.pop_front();
          check_field("failed", COLOR_W'(seen.failed), COLOR_W'(want.failed));
          check_field("result_index", COLOR_W'(seen.res_index), COLOR_W'(want.res_index));
          check_field("current_color", seen.colour, want.colour);
          check_field("entry_count", COLOR_W'(seen.count), COLOR_W'(want.count));
          check_field("selected_index", COLOR_W'(seen.sel_index), COLOR_W'(want.sel_index));
          check_field("selection_valid", COLOR_W'(seen.sel_valid), COLOR_W'(want.sel_valid));
        end
      end
      if (in_tvalid && in_tready)
        palette_results_due.push_back(predict_palette_action(
            in_tdata[ACTION_W-1:0], in_tdata[ACTION_W +: COLOR_W],
            in_tdata[ACTION_W+COLOR_W +: WIDX_W]));
    end
  end

  // send one transaction, with random idle cycles before it
  task automatic send_item(action_t act, logic [COLOR_W-1:0] colour, int widx);
    logic [WIDX_W-1:0] widx_bits;
    bit                ready_seen;
    widx_bits = widx[WIDX_W-1:0];
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({widx_bits, colour, act});
    // in_tready is stable between edges, so sample it mid-cycle
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
  endtask

  // colour from those already stored, often nudged, or a fresh one
  function automatic logic [COLOR_W-1:0] pick_colour(colour_q_t known, int reuse_pct);
    logic [COLOR_W-1:0] c;
    if (known.size() > 0 && $urandom_range(99) < reuse_pct) begin
      c = known[$urandom_range(known.size() - 1)];
      if ($urandom_range(1))
        c = c ^ (COLOR_W'($urandom) & 24'h030303);
    end else begin
      case ($urandom_range(9))
        0:       c = '0;
        1:       c = '1;
        default: c = COLOR_W'($urandom);
      endcase
    end
    return c;
  endfunction

  // selects, read and clear on an empty palette
  task automatic test_empty_palette();
    send_item(ACT_READ, 24'h000000, 0);
    send_item(ACT_SEL_INDEX, 24'h000000, 0);
    send_item(ACT_SEL_NEAREST, 24'hffffff, 0);
    send_item(ACT_CLEAR, 24'h000000, 0);
  endtask

  // first add becomes the selection; extreme colours
  task automatic test_first_add_and_extremes();
    send_item(ACT_ADD, 24'h000000, 0);
    send_item(ACT_ADD, 24'hffffff, 0);
    send_item(ACT_ADD, 24'hff0000, 0);
    send_item(ACT_ADD, 24'h00ff00, 0);
    send_item(ACT_ADD, 24'h0000ff, 0);
    send_item(ACT_READ, 24'h000000, 0);
  endtask

  // index clamping: in range, negative, at and above the count
  task automatic test_select_index_clamp();
    send_item(ACT_SEL_INDEX, 24'h000000, 3);
    send_item(ACT_SEL_INDEX, 24'h000000, -1);
    send_item(ACT_SEL_INDEX, 24'h000000, -256);
    send_item(ACT_SEL_INDEX, 24'h000000, 255);
    send_item(ACT_SEL_INDEX, 24'h000000, 5);
    send_item(ACT_SEL_INDEX, 24'h000000, 4);
    send_item(ACT_SEL_INDEX, 24'h000000, 2);
  endtask

  // nearest search: exact match on a duplicate, near-grey and near-blue probes
  task automatic test_select_nearest();
    send_item(ACT_ADD, 24'hff0000, 0);
    send_item(ACT_SEL_NEAREST, 24'hff0000, 0);
    send_item(ACT_SEL_NEAREST, 24'h7f7f7f, 0);
    send_item(ACT_SEL_NEAREST, 24'h808080, 0);
    send_item(ACT_SEL_NEAREST, 24'h0000fe, 0);
  endtask

  // clear drops the palette and the selection
  task automatic test_clear_palette();
    send_item(ACT_CLEAR, 24'h000000, 0);
    send_item(ACT_SEL_NEAREST, 24'h000000, 0);
    send_item(ACT_SEL_INDEX, 24'h000000, 1);
    send_item(ACT_READ, 24'h000000, 0);
    send_item(ACT_ADD, 24'h123456, 0);
  endtask

  // sessions: usually a clear, then a fill (sometimes past full), then mixed actions
  task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
    colour_q_t          added;
    logic [COLOR_W-1:0] c;
    int                 sent;
    int                 fill;
    int                 pick;
    int                 widx;
    sent = 0;
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    while (sent < n_items) begin
      if ($urandom_range(3) != 0) begin
        send_item(ACT_CLEAR, COLOR_W'($urandom), $urandom);
        added.delete();
        sent++;
      end
      fill = ($urandom_range(3) == 0) ? DEPTH + $urandom_range(2) : $urandom_range(1, DEPTH - 1);
      for (int k = added.size(); k < fill; k++) begin
        c = pick_colour(added, 20);
        send_item(ACT_ADD, c, $urandom);
        if (added.size() < DEPTH)
          added.push_back(c);
        sent++;
      end
      repeat ($urandom_range(4, 12)) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          send_item(ACT_SEL_NEAREST, pick_colour(added, 50), $urandom);
        end else if (pick < 60) begin
          case ($urandom_range(3))
            0:       widx = -int'($urandom_range(1, 256));
            1:       widx = int'($urandom_range(511)) - 256;
            default: widx = $urandom_range(0, added.size() + 2);
          endcase
          send_item(ACT_SEL_INDEX, COLOR_W'($urandom), widx);
        end else if (pick < 78) begin
          c = pick_colour(added, 25);
          send_item(ACT_ADD, c, $urandom);
          if (added.size() < DEPTH)
            added.push_back(c);
        end else if (pick < 93) begin
          send_item(ACT_READ, COLOR_W'($urandom), $urandom);
        end else begin
          send_item(ACT_CLEAR, COLOR_W'($urandom), $urandom);
          added.delete();
        end
        sent++;
      end
    end
  endtask

  // reset, tests in turn, drain, verdict
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_palette();
    test_first_add_and_extremes();
    test_select_index_clamp();
    test_select_nearest();
    test_clear_palette();
    test_random_traffic(0, 0, 100);
    test_random_traffic(79, 0, 100);
    test_random_traffic(0, 79, 100);
    test_random_traffic(8, 8, 100);
    in_tvalid <= 1'b0;
    while (palette_results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("[palette_store_nearest_color_top] OK");
    end else begin
      $display("[palette_store_nearest_color_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- palette_store_nearest_color_top.f -----
rtl/core/psnc_pkg.sv
rtl/core/psnc_dist.sv
rtl/core/palette_store_nearest_color_top.sv
rtl/core/psnc_checker.sv
test/tb.sv
